// ===== rtl/fct_pkg.sv =====
`timescale 1ns / 1ps
// fct_pkg: types and constants for the fraction arithmetic block.
// Used by fct_div, fraction_arithmetic_reduce and tb; no dependencies.
package fct_pkg;

  localparam int unsigned OPERAND_W = 16;
  localparam int unsigned MAG_W     = 2 * OPERAND_W;
  localparam int unsigned NUM_W     = 33;
  localparam int unsigned DEN_W     = 31;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_COMB,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e                          operation;
    logic signed [OPERAND_W-1:0]  first_num;
    logic signed [OPERAND_W-1:0]  first_den;
    logic signed [OPERAND_W-1:0]  second_num;
    logic signed [OPERAND_W-1:0]  second_den;
  } req_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] result_num;
    logic [DEN_W-1:0]        result_den;
    logic                    zero_divisor;
  } rsp_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/fct_div.sv =====
`timescale 1ns / 1ps
// fct_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on fct_pkg.
module fct_div import fct_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MAG_W-1:0] dividend_i,
  input  logic [MAG_W-1:0] divisor_i,
  output div_rsp_t         rsp_o
);

  localparam int unsigned CNT_W = $clog2(MAG_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0] rem_q, rem_d;
  logic [MAG_W-1:0] quo_q, quo_d;
  logic [MAG_W-1:0] dvs_q, dvs_d;

  logic [MAG_W:0]   shifted;
  logic [MAG_W:0]   trial;
  logic             fits;

  assign shifted = {rem_q, quo_q[MAG_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? trial[MAG_W-1:0] : shifted[MAG_W-1:0];
      quo_d = {quo_q[MAG_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == CNT_LAST && !start_i) |=> done_q)
    else $error("divider missed its last step");
`endif

endmodule

// ===== rtl/fraction_arithmetic_reduce.sv =====
`timescale 1ns / 1ps
// fraction_arithmetic_reduce: signed fraction add/sub/mul/div with reduction.
// Steps: multiply (products in turn on the shared multiplier), combine, binary GCD loop, then the
// divider runs for numerator and denominator. One request at a time; in_stall_o is high until idle.
// Zero numerator or zero denominator requests skip the GCD loop and the divider.
// Reset (rst_ni low, asynchronous) returns to idle and drops out_valid_o. Depends on fct_pkg, fct_div.
module fraction_arithmetic_reduce import fct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam logic [1:0] MUL_LAST = 2'd2;

  state_e state_q, state_d;

  op_e                  op_q;
  logic [OPERAND_W-1:0] mag_q [4];
  logic                 neg_in_q [4];
  logic [1:0]           mul_cnt_q, mul_cnt_d;
  logic [MAG_W-1:0]     prod_q [3];
  logic                 pneg_q [3];

  logic [MAG_W-1:0] u_q, u_d, v_q, v_d, nq_q, nq_d, mq_q, mq_d;
  logic [MAG_W-1:0] rnum_q, rnum_d, rden_q, rden_d;
  logic             neg_q, neg_d, zdiv_q, zdiv_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_rsp_q, out_rsp_d;

  logic                 accept;
  logic                 out_free;
  logic [OPERAND_W-1:0] mx, my;
  logic                 mxn, myn;
  logic [MAG_W-1:0]     prod;

  logic             s1neg;
  logic [MAG_W-1:0] n_mag;
  logic             n_neg;
  logic             p_ge;

  logic             gcd_eq, u_gt;
  logic [MAG_W-1:0] gcd_diff;

  logic             div_start;
  logic [MAG_W-1:0] div_dividend;
  div_rsp_t         div_rsp;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // operand magnitudes and signs of the request
  function automatic logic [OPERAND_W-1:0] mag_of(logic [OPERAND_W-1:0] v);
    mag_of = v[OPERAND_W-1] ? (~v + OPERAND_W'(1)) : v;
  endfunction

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= in_req_i.operation;
      mag_q[0]    <= mag_of(in_req_i.first_num);
      mag_q[1]    <= mag_of(in_req_i.first_den);
      mag_q[2]    <= mag_of(in_req_i.second_num);
      mag_q[3]    <= mag_of(in_req_i.second_den);
      neg_in_q[0] <= in_req_i.first_num[OPERAND_W-1];
      neg_in_q[1] <= in_req_i.first_den[OPERAND_W-1];
      neg_in_q[2] <= in_req_i.second_num[OPERAND_W-1];
      neg_in_q[3] <= in_req_i.second_den[OPERAND_W-1];
    end
  end

  // shared multiplier: p0 = a*d (a*c for mul), p1 = c*b, p2 = b*d (b*c for div)
  always_comb begin
    case (mul_cnt_q)
      2'd0: begin
        mx  = mag_q[0];
        mxn = neg_in_q[0];
        my  = (op_q == OP_MUL) ? mag_q[2] : mag_q[3];
        myn = (op_q == OP_MUL) ? neg_in_q[2] : neg_in_q[3];
      end
      2'd1: begin
        mx  = mag_q[2];
        mxn = neg_in_q[2];
        my  = mag_q[1];
        myn = neg_in_q[1];
      end
      default: begin
        mx  = mag_q[1];
        mxn = neg_in_q[1];
        my  = (op_q == OP_DIV) ? mag_q[2] : mag_q[3];
        myn = (op_q == OP_DIV) ? neg_in_q[2] : neg_in_q[3];
      end
    endcase
  end

  assign prod = MAG_W'(mx) * MAG_W'(my);

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL && mul_cnt_q <= MUL_LAST) begin
      prod_q[mul_cnt_q] <= prod;
      pneg_q[mul_cnt_q] <= mxn ^ myn;
    end
  end

  // signed combine of the two cross products for add/sub; mul and div pass p0 through
  always_comb begin
    s1neg = pneg_q[1] ^ (op_q == OP_SUB);
    p_ge  = prod_q[0] >= prod_q[1];
    if (op_q == OP_MUL || op_q == OP_DIV) begin
      n_mag = prod_q[0];
      n_neg = pneg_q[0];
    end else if (pneg_q[0] == s1neg) begin
      n_mag = prod_q[0] + prod_q[1];
      n_neg = pneg_q[0];
    end else if (p_ge) begin
      n_mag = prod_q[0] - prod_q[1];
      n_neg = pneg_q[0];
    end else begin
      n_mag = prod_q[1] - prod_q[0];
      n_neg = s1neg;
    end
  end

  assign gcd_eq   = u_q == v_q;
  assign u_gt     = u_q > v_q;
  assign gcd_diff = u_gt ? (u_q - v_q) : (v_q - u_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_MUL;
      S_MUL:  if (mul_cnt_q == MUL_LAST) state_d = S_COMB;
      S_COMB: begin
        if (prod_q[2] == '0 || n_mag == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_GCD;
        end
      end
      S_GCD:  if (gcd_eq) state_d = S_DIVN;
      S_DIVN: if (div_rsp.done) state_d = S_DIVD;
      S_DIVD: if (div_rsp.done) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mul_cnt_d    = mul_cnt_q;
    u_d          = u_q;
    v_d          = v_q;
    nq_d         = nq_q;
    mq_d         = mq_q;
    rnum_d       = rnum_q;
    rden_d       = rden_q;
    neg_d        = neg_q;
    zdiv_d       = zdiv_q;
    div_start    = 1'b0;
    div_dividend = nq_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_rsp_d    = out_rsp_q;
    case (state_q)
      S_IDLE: mul_cnt_d = '0;
      S_MUL:  mul_cnt_d = mul_cnt_q + 2'd1;
      S_COMB: begin
        neg_d  = n_neg ^ pneg_q[2];
        zdiv_d = prod_q[2] == '0;
        rnum_d = '0;
        rden_d = (prod_q[2] == '0) ? '0 : MAG_W'(1);
        u_d    = n_mag;
        v_d    = prod_q[2];
        nq_d   = n_mag;
        mq_d   = prod_q[2];
      end
      S_GCD: begin
        if (gcd_eq) begin
          div_start = 1'b1;
        end else if (!u_q[0] && !v_q[0]) begin
          u_d  = u_q >> 1;
          v_d  = v_q >> 1;
          nq_d = nq_q >> 1;
          mq_d = mq_q >> 1;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (u_gt) begin
          u_d = gcd_diff >> 1;
        end else begin
          v_d = gcd_diff >> 1;
        end
      end
      S_DIVN: begin
        div_dividend = mq_q;
        if (div_rsp.done) begin
          rnum_d    = div_rsp.quot;
          div_start = 1'b1;
        end
      end
      S_DIVD: if (div_rsp.done) rden_d = div_rsp.quot;
      S_DONE: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_rsp_d.zero_divisor  = zdiv_q;
          out_rsp_d.result_den    = rden_q[DEN_W-1:0];
          out_rsp_d.result_num    = neg_q ? -NUM_W'(rnum_q) : NUM_W'(rnum_q);
        end
      end
      default: ;
    endcase
  end

  fct_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (u_q),
    .rsp_o      (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mul_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mul_cnt_q   <= mul_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q       <= u_d;
    v_q       <= v_d;
    nq_q      <= nq_d;
    mq_q      <= mq_d;
    rnum_q    <= rnum_d;
    rden_q    <= rden_d;
    neg_q     <= neg_d;
    zdiv_q    <= zdiv_d;
    out_rsp_q <= out_rsp_d;
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTHESIS
  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_GCD |-> (u_q != '0 && v_q != '0))
    else $error("gcd operand reached zero");
  a_zdiv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.zero_divisor) |->
      (out_rsp_o.result_num == '0 && out_rsp_o.result_den == '0))
    else $error("zero divisor result not 0/0");
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_rsp_o.zero_divisor) |-> out_rsp_o.result_den != '0)
    else $error("zero denominator without flag");
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIVN || state_q == S_DIVD))
    else $error("divider finished outside a divide step");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for fraction_arithmetic_reduce (fct_pkg request/result types).
// A scoreboard class predicts each reduced fraction; plain tasks drive random and directed traffic.
module tb;
  import fct_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int unsigned RANDOM_REQS = 450;

  class frac_scoreboard;
    rsp_t        expected_rsp[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function rsp_t reduce_fraction(req_t r);
      longint a, b, c, d, n, m, x, y, t;
      rsp_t   res;
      a = longint'(r.first_num);
      b = longint'(r.first_den);
      c = longint'(r.second_num);
      d = longint'(r.second_den);
      case (r.operation)
        OP_ADD: begin
          n = a * d + c * b;
          m = b * d;
        end
        OP_SUB: begin
          n = a * d - c * b;
          m = b * d;
        end
        OP_MUL: begin
          n = a * c;
          m = b * d;
        end
        default: begin
          n = a * d;
          m = b * c;
        end
      endcase
      res = '0;
      if (m == 0) begin
        res.zero_divisor = 1'b1;
        return res;
      end
      if (m < 0) begin
        m = -m;
        n = -n;
      end
      // gcd of magnitudes; a zero numerator gives gcd = m, hence 0/1
      x = (n < 0) ? -n : n;
      y = m;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      res.result_num = NUM_W'(n / x);
      res.result_den = DEN_W'(m / x);
      return res;
    endfunction

    function void note_request(req_t r);
      expected_rsp.push_back(reduce_fraction(r));
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp_rsp;
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected result num=%0d den=%0d zdiv=%0b", $time,
                 got.result_num, got.result_den, got.zero_divisor);
        errors++;
        return;
      end
      exp_rsp = expected_rsp.pop_front();
      if (got.result_num !== exp_rsp.result_num) begin
        $display("%0t: result_num expected %0d actual %0d", $time,
                 exp_rsp.result_num, got.result_num);
        errors++;
      end
      if (got.result_den !== exp_rsp.result_den) begin
        $display("%0t: result_den expected %0d actual %0d", $time,
                 exp_rsp.result_den, got.result_den);
        errors++;
      end
      if (got.zero_divisor !== exp_rsp.zero_divisor) begin
        $display("%0t: zero_divisor expected %0b actual %0b", $time,
                 exp_rsp.zero_divisor, got.zero_divisor);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_stall_i;
  rsp_t out_rsp_o;

  frac_scoreboard sb = new();
  bit             send_calm;
  bit             recv_calm;
  int unsigned    idle_cycles = 0;

  fraction_arithmetic_reduce DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (in_valid_i && !in_stall_o) begin
        sb.note_request(in_req_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_response(out_rsp_o);
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result side: a stall, when drawn, is raised ahead of and held over the result
  initial begin
    int unsigned hold;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      hold = recv_calm ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        do @(posedge clk_i); while (!out_valid_o);
        repeat (hold - 1) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic req_t make_req(op_e op, int a, int b, int c, int d);
    req_t r;
    r.operation  = op;
    r.first_num  = OPERAND_W'(a);
    r.first_den  = OPERAND_W'(b);
    r.second_num = OPERAND_W'(c);
    r.second_den = OPERAND_W'(d);
    return r;
  endfunction

  function automatic logic signed [OPERAND_W-1:0] rand_operand(bit narrow);
    if (narrow) begin
      return OPERAND_W'(int'($urandom_range(0, 40)) - 20);
    end
    return OPERAND_W'($urandom);
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned kind;
    bit          narrow;
    kind         = $urandom_range(0, 19);
    narrow       = (kind >= 8);
    r.operation  = op_e'($urandom_range(0, 3));
    r.first_num  = rand_operand(narrow);
    r.first_den  = rand_operand(narrow);
    r.second_num = rand_operand(narrow);
    r.second_den = rand_operand(narrow);
    if (kind < 19) begin
      if (r.first_den == 0) r.first_den = OPERAND_W'(1);
      if (r.second_den == 0) r.second_den = '1;
      if (r.operation == OP_DIV && r.second_num == 0) r.second_num = OPERAND_W'(1);
    end
    if (kind == 18) begin
      r.first_num = '0;
      if (r.operation != OP_DIV) r.second_num = '0;
    end else if (kind == 19) begin
      case ($urandom_range(0, 2))
        0: r.first_den = '0;
        1: r.second_den = '0;
        default: begin
          r.operation  = OP_DIV;
          r.second_num = '0;
        end
      endcase
    end
    return r;
  endfunction

  task automatic send_request(input req_t r);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_rsp.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    req_t directed[$];
    int unsigned mode;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    send_calm   = 1'b0;
    recv_calm   = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(make_req(OP_ADD, 1, 2, 1, 3));
    directed.push_back(make_req(OP_SUB, 1, 2, 1, 2));
    directed.push_back(make_req(OP_MUL, 2, 3, 3, 4));
    directed.push_back(make_req(OP_DIV, 1, 2, -1, 4));
    directed.push_back(make_req(OP_ADD, 32767, 1, 32767, 1));
    directed.push_back(make_req(OP_ADD, -32768, -32768, -32768, -32768));
    directed.push_back(make_req(OP_ADD, -32768, -32767, -32768, -32767));
    directed.push_back(make_req(OP_SUB, -32768, 1, 32767, 1));
    directed.push_back(make_req(OP_SUB, 32767, -32768, -32768, 32767));
    directed.push_back(make_req(OP_MUL, -32768, 1, -32768, 1));
    directed.push_back(make_req(OP_MUL, 32767, -1, -32768, 32767));
    directed.push_back(make_req(OP_DIV, 32767, -32768, -32768, 32767));
    directed.push_back(make_req(OP_DIV, 32767, 32767, 32767, 32767));
    directed.push_back(make_req(OP_ADD, -1, -1, -1, -1));
    directed.push_back(make_req(OP_SUB, 3, -4, 5, 6));
    directed.push_back(make_req(OP_ADD, 1, 0, 1, 1));
    directed.push_back(make_req(OP_MUL, 1, 1, 1, 0));
    directed.push_back(make_req(OP_SUB, -32768, 0, 32767, 0));
    directed.push_back(make_req(OP_DIV, 5, 3, 0, 7));
    directed.push_back(make_req(OP_DIV, 0, 3, 0, 7));
    directed.push_back(make_req(OP_ADD, 0, 5, 0, -7));
    directed.push_back(make_req(OP_MUL, 0, -3, 9, -5));
    directed.push_back(make_req(OP_SUB, 7, 9, 7, 9));
    directed.push_back(make_req(OP_DIV, -32768, -1, -1, 32767));
    foreach (directed[i]) send_request(directed[i]);
    wait_all_results();

    for (int unsigned i = 0; i < RANDOM_REQS; i++) begin
      if (i % 50 == 0) begin
        mode      = $urandom_range(0, 3);
        send_calm = (mode == 0 || mode == 1);
        recv_calm = (mode == 0 || mode == 2);
      end
      // hold off until the pipe is empty, at the midpoint and now and then
      if (i == RANDOM_REQS / 2 || (!send_calm && $urandom_range(0, 2) == 0)) begin
        wait_all_results();
      end
      send_request(random_request());
    end

    wait_all_results();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
